/* sv/dxtbd_pkg.sv */
// ----------------------------------------------------------------------------
// dxtbd_pkg
// Shared types, format codes and small arithmetic helpers for the DXT block
// decoder: 565 endpoint expansion and constant divides by reciprocal.
// ----------------------------------------------------------------------------
package dxtbd_pkg;

    localparam logic [1:0] FMT_COLOR_ONLY     = 2'd0;
    localparam logic [1:0] FMT_ALPHA_EXPLICIT = 2'd1;
    localparam logic [1:0] FMT_ALPHA_INTERP   = 2'd2;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    typedef struct packed {
        t_rgb [3:0]       color;
        logic [7:0][7:0]  atab;
    } t_pal;

    function automatic logic [7:0] exp5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] exp6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // floor(x/3) for x < 768
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = {11'd0, x} * 21'd683;
        return p[18:11];
    endfunction

    // floor(x/5) for x < 1280
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [21:0] p;
        p = {11'd0, x} * 22'd1639;
        return p[20:13];
    endfunction

    // floor(x/7) for x < 1792
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = {12'd0, x} * 23'd2341;
        return p[21:14];
    endfunction

endpackage

/* sv/dxtbd_palette.sv */
// ----------------------------------------------------------------------------
// dxtbd_palette
// Builds the four-entry color palette and the eight-entry alpha table of one
// compressed block.
// ----------------------------------------------------------------------------
module dxtbd_palette (
    input  logic [63:0]      i_alpha_half,
    input  logic [63:0]      i_color_half,
    input  logic [1:0]       i_fmt,
    output dxtbd_pkg::t_pal  o_pal
);

    logic [15:0]      c0;
    logic [15:0]      c1;
    logic             four;
    dxtbd_pkg::t_rgb  e0;
    dxtbd_pkg::t_rgb  e1;
    logic [7:0]       a0;
    logic [7:0]       a1;

    assign c0   = i_color_half[15:0];
    assign c1   = i_color_half[31:16];
    assign four = (i_fmt != dxtbd_pkg::FMT_COLOR_ONLY) || (c0 > c1);
    assign a0   = i_alpha_half[7:0];
    assign a1   = i_alpha_half[15:8];

    assign e0.red   = dxtbd_pkg::exp5(c0[15:11]);
    assign e0.green = dxtbd_pkg::exp6(c0[10:5]);
    assign e0.blue  = dxtbd_pkg::exp5(c0[4:0]);
    assign e1.red   = dxtbd_pkg::exp5(c1[15:11]);
    assign e1.green = dxtbd_pkg::exp6(c1[10:5]);
    assign e1.blue  = dxtbd_pkg::exp5(c1[4:0]);

    always_comb begin
        logic [2:0][7:0] v0;
        logic [2:0][7:0] v1;
        logic [8:0]      half;
        logic [10:0]     s;
        o_pal = '0;
        half  = '0;
        s     = '0;
        v0 = e0;
        v1 = e1;
        o_pal.color[0] = e0;
        o_pal.color[1] = e1;
        for (int k = 0; k < 3; k++) begin
            if (four) begin
                o_pal.color[2][k*8 +: 8] =
                    dxtbd_pkg::div3({1'b0, v0[k], 1'b0} + {2'b0, v1[k]});
                o_pal.color[3][k*8 +: 8] =
                    dxtbd_pkg::div3({2'b0, v0[k]} + {1'b0, v1[k], 1'b0});
            end else begin
                half = {1'b0, v0[k]} + {1'b0, v1[k]};
                o_pal.color[2][k*8 +: 8] = half[8:1];
                o_pal.color[3][k*8 +: 8] = 8'd0;
            end
        end

        o_pal.atab[0] = a0;
        o_pal.atab[1] = a1;
        if (a0 > a1) begin
            for (int k = 1; k < 7; k++) begin
                s = {3'd0, a0} * 11'(7 - k) + {3'd0, a1} * 11'(k);
                o_pal.atab[k + 1] = dxtbd_pkg::div7(s);
            end
        end else begin
            for (int k = 1; k < 5; k++) begin
                s = {3'd0, a0} * 11'(5 - k) + {3'd0, a1} * 11'(k);
                o_pal.atab[k + 1] = dxtbd_pkg::div5(s);
            end
            o_pal.atab[6] = 8'd0;
            o_pal.atab[7] = 8'd255;
        end
    end

endmodule

/* sv/dxt_block_decoder_core.sv */
// ----------------------------------------------------------------------------
// dxt_block_decoder_core
// DXT1/DXT3/DXT5 block decoder: one compressed 4x4 block in, sixteen
// texels out in row-major order.
//
//   channel   dir  width  per beat
//   s_axis    in   128    one compressed block (alpha half, color half)
//   m_axis    out  40     one decoded texel, tlast on texel 15
//   cfg       in   2      block format, written while idle
//
// A block is captured in the input register, then its palette is built
// into the decode register, which emits one texel per cycle through the
// output register whenever that register is empty or being taken. The first
// texel is offered from the output register after passing the input and
// decode registers. The next block loads while the current one drains.
// Reset clears all valid flags and the format to DXT1.
// ----------------------------------------------------------------------------
module dxt_block_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,  // alpha_half[63:0], color_half[127:64]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // texel_index[3:0], red[11:4],
                                          // green[19:12], blue[27:20],
                                          // alpha[35:28], zero[39:36]
    output logic        o_m_axis_tlast    // last_texel
);

    logic [1:0]        r_fmt;

    logic              r_s1_valid;
    logic [63:0]       r_s1_alpha;
    logic [63:0]       r_s1_color;

    logic              r_s2_valid;
    dxtbd_pkg::t_pal   r_s2_pal;
    logic [31:0]       r_s2_cidx;
    logic [63:0]       r_s2_nib;
    logic [47:0]       r_s2_aidx;
    logic [3:0]        r_s2_cnt;

    logic              r_out_valid;
    logic [35:0]       r_out_data;
    logic              r_out_last;

    dxtbd_pkg::t_pal   pal;
    logic              out_adv;
    logic              emit;
    logic              s2_done;
    logic              s2_load;
    logic              s1_free;
    logic              accept;
    dxtbd_pkg::t_rgb   texel_rgb;
    logic [7:0]        texel_opacity;

    dxtbd_palette u_palette (
        .i_alpha_half (r_s1_alpha),
        .i_color_half (r_s1_color),
        .i_fmt        (r_fmt),
        .o_pal        (pal)
    );

    assign out_adv = !r_out_valid || i_m_axis_tready;
    assign emit    = r_s2_valid && out_adv;
    assign s2_done = emit && (r_s2_cnt == 4'd15);
    assign s2_load = r_s1_valid && (!r_s2_valid || s2_done);
    assign s1_free = !r_s1_valid || s2_load;
    assign accept  = i_s_axis_tvalid && s1_free;

    assign o_s_axis_tready = s1_free;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_data};
    assign o_m_axis_tlast  = r_out_last;

    always_comb begin
        texel_rgb = r_s2_pal.color[r_s2_cidx[1:0]];
        case (r_fmt)
            dxtbd_pkg::FMT_COLOR_ONLY:     texel_opacity = 8'd255;
            dxtbd_pkg::FMT_ALPHA_EXPLICIT: texel_opacity = {r_s2_nib[3:0], r_s2_nib[3:0]};
            default:                       texel_opacity = r_s2_pal.atab[r_s2_aidx[2:0]];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= dxtbd_pkg::FMT_COLOR_ONLY;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
        if (accept) begin
            r_s1_alpha <= i_s_axis_tdata[63:0];
            r_s1_color <= i_s_axis_tdata[127:64];
        end
    end

    // decode register: hold palette, advance texel indices per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s2_cnt   <= 4'd0;
        end else if (s2_load) begin
            r_s2_valid <= 1'b1;
            r_s2_cnt   <= 4'd0;
        end else if (emit) begin
            r_s2_valid <= !s2_done;
            r_s2_cnt   <= r_s2_cnt + 4'd1;
        end
        if (s2_load) begin
            r_s2_pal  <= pal;
            r_s2_cidx <= r_s1_color[63:32];
            r_s2_nib  <= r_s1_alpha;
            r_s2_aidx <= r_s1_alpha[63:16];
        end else if (emit) begin
            r_s2_cidx <= {2'd0, r_s2_cidx[31:2]};
            r_s2_nib  <= {4'd0, r_s2_nib[63:4]};
            r_s2_aidx <= {3'd0, r_s2_aidx[47:3]};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s2_valid;
        end
        if (emit) begin
            r_out_data <= {texel_opacity, texel_rgb.blue, texel_rgb.green,
                           texel_rgb.red, r_s2_cnt};
            r_out_last <= (r_s2_cnt == 4'd15);
        end
    end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for dxt_block_decoder_core. Compressed blocks go in on
// the slave stream and each accepted beat is decoded in the bench into sixteen
// texels, which are matched field by field against the master stream. A short
// directed set covers endpoint orderings, palette modes and alpha tables for
// every format code, then random blocks run under varied valid/ready idling,
// including one long output stall that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] FMT_RESERVED = 2'd3;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         TAIL_CYCLES  = 20;
    localparam int         LIMIT_TIME   = 400000;

    typedef struct packed {
        logic [3:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } t_texel;

    class t_texel_scoreboard;
        logic [1:0] fmt = dxtbd_pkg::FMT_COLOR_ONLY;
        t_texel     texel_q[$];
        int         fail_count = 0;

        function int widen(int v, int bits);
            return (bits == 5) ? ((v << 3) | (v >> 2)) : ((v << 2) | (v >> 4));
        endfunction

        function void note_block(logic [63:0] ah, logic [63:0] ch);
            int     pal[4][3];
            int     atab[8];
            int     c0;
            int     c1;
            int     w;
            int     ci;
            bit     four;
            t_texel t;
            c0 = int'(ch[15:0]);
            c1 = int'(ch[31:16]);
            four = (fmt != dxtbd_pkg::FMT_COLOR_ONLY) || (c0 > c1);
            for (int e = 0; e < 2; e++) begin
                w = (e == 0) ? c0 : c1;
                pal[e][0] = widen((w >> 11) & 'h1f, 5);
                pal[e][1] = widen((w >> 5) & 'h3f, 6);
                pal[e][2] = widen(w & 'h1f, 5);
            end
            for (int k = 0; k < 3; k++) begin
                if (four) begin
                    pal[2][k] = (2 * pal[0][k] + pal[1][k]) / 3;
                    pal[3][k] = (pal[0][k] + 2 * pal[1][k]) / 3;
                end else begin
                    pal[2][k] = (pal[0][k] + pal[1][k]) / 2;
                    pal[3][k] = 0;
                end
            end
            atab[0] = int'(ah[7:0]);
            atab[1] = int'(ah[15:8]);
            if (atab[0] > atab[1]) begin
                for (int k = 1; k < 7; k++)
                    atab[k + 1] = ((7 - k) * atab[0] + k * atab[1]) / 7;
            end else begin
                for (int k = 1; k < 5; k++)
                    atab[k + 1] = ((5 - k) * atab[0] + k * atab[1]) / 5;
                atab[6] = 0;
                atab[7] = 255;
            end
            for (int i = 0; i < 16; i++) begin
                ci = int'(ch[32 + 2 * i +: 2]);
                t.index = 4'(i);
                t.red   = 8'(pal[ci][0]);
                t.green = 8'(pal[ci][1]);
                t.blue  = 8'(pal[ci][2]);
                case (fmt)
                    dxtbd_pkg::FMT_COLOR_ONLY:     t.alpha = 8'd255;
                    dxtbd_pkg::FMT_ALPHA_EXPLICIT: t.alpha = 8'(int'(ah[4 * i +: 4]) * 17);
                    default:                       t.alpha = 8'(atab[ah[16 + 3 * i +: 3]]);
                endcase
                t.last = (i == 15);
                texel_q.push_back(t);
            end
        endfunction

        function void compare(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                fail_count++;
            end
        endfunction

        function void check_texel(logic [39:0] data, logic last);
            t_texel want;
            if (texel_q.size() == 0) begin
                $display("%0t: unexpected texel, expected none, actual %h last %b",
                         $time, data, last);
                fail_count++;
                return;
            end
            want = texel_q.pop_front();
            compare("texel_index", want.index, data[3:0]);
            compare("red", want.red, data[11:4]);
            compare("green", want.green, data[19:12]);
            compare("blue", want.blue, data[27:20]);
            compare("alpha", want.alpha, data[35:28]);
            compare("pad", 0, data[39:36]);
            compare("tlast", want.last, last);
        endfunction

        function int pending();
            return texel_q.size();
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_wdata = dxtbd_pkg::FMT_COLOR_ONLY;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [39:0]  o_m_axis_tdata;
    logic         o_m_axis_tlast;

    t_texel_scoreboard sb = new();
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_request = 0;
    int                hold_left = 0;

    dxt_block_decoder_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #(LIMIT_TIME);
        $display("tb_top: FAIL");
        $finish;
    end

    // long receiver hold, counted in cycles
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left <= hold_request;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_texel(o_m_axis_tdata, o_m_axis_tlast);
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_block(logic [63:0] ah, logic [63:0] ch);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {ch, ah};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_block(ah, ch);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_format(logic [1:0] fmt);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= fmt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.fmt = fmt;
    endtask

    task automatic run_random(logic [1:0] fmt, int s_pct, int r_pct, int count, int hold);
        logic [63:0] ah;
        logic [63:0] ch;
        write_format(fmt);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        if (hold > 0) begin
            hold_request <= hold;
            @(posedge i_clk);
            hold_request <= 0;
        end
        repeat (count) begin
            ah = {$urandom, $urandom};
            ch = {$urandom, $urandom};
            if ($urandom_range(7) == 0)
                ch[31:16] = ch[15:0];
            if ($urandom_range(7) == 0)
                ah[15:8] = ah[7:0];
            send_block(ah, ch);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_format(dxtbd_pkg::FMT_COLOR_ONLY);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block(64'h0, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
        send_block(64'h0, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
        send_block(64'h0, {32'h1B1B1B1B, 16'h07E0, 16'hF800});
        send_block(64'h0, {32'hE4E4E4E4, 16'h001F, 16'h001F});

        write_format(dxtbd_pkg::FMT_ALPHA_EXPLICIT);
        send_block(64'hFEDCBA9876543210, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
        send_block(64'h0123456789ABCDEF, {32'h4E4E4E4E, 16'h8410, 16'h8410});
        send_block('1, '1);
        send_block(64'h0, 64'h0);

        write_format(dxtbd_pkg::FMT_ALPHA_INTERP);
        send_block({48'hFAC688FAC688, 8'h00, 8'hFF}, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
        send_block({48'hFAC688FAC688, 8'hFF, 8'h00}, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
        send_block({48'hFAC688FAC688, 8'h80, 8'h80}, {32'h1B1B1B1B, 16'h07E0, 16'hF800});
        send_block({48'hFAC688FAC688, 8'h00, 8'h01}, {32'hB1B1B1B1, 16'h001F, 16'hF81F});
        send_block({48'hFAC688FAC688, 8'hFF, 8'hFE}, {32'h72727272, 16'hAAAA, 16'h5555});
        send_block('1, '1);

        write_format(FMT_RESERVED);
        send_block({48'hFAC688FAC688, 8'h20, 8'hC0}, {32'hE4E4E4E4, 16'h1234, 16'h4321});
        send_block({48'hFAC688FAC688, 8'hC0, 8'h20}, {32'hE4E4E4E4, 16'h4321, 16'h1234});

        run_random(dxtbd_pkg::FMT_COLOR_ONLY,     0,  0,  40, 0);
        run_random(dxtbd_pkg::FMT_ALPHA_INTERP,   49, 0,  40, 0);
        run_random(dxtbd_pkg::FMT_ALPHA_EXPLICIT, 0,  49, 40, 0);
        run_random(dxtbd_pkg::FMT_ALPHA_INTERP,   27, 27, 40, 0);
        run_random(dxtbd_pkg::FMT_COLOR_ONLY,     27, 27, 30, 0);
        run_random(FMT_RESERVED,                  49, 0,  20, 0);
        run_random(dxtbd_pkg::FMT_ALPHA_EXPLICIT, 0,  0,  40, HOLD_CYCLES);
        run_random(dxtbd_pkg::FMT_ALPHA_INTERP,   0,  0,  30, 0);
        run_random(dxtbd_pkg::FMT_COLOR_ONLY,     0,  49, 30, 0);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
